[design/i2cbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cbd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LINE_W   = 4;
  localparam int COUNT_W  = 9;
  localparam int BYTE_W   = 8;
  localparam int BITPOS_W = 4;

  localparam logic [BITPOS_W-1:0] BITPOS_FIRST = 4'd7;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SCL_LINE  = 2'd0;
  localparam logic [1:0] REG_SDA_LINE  = 2'd1;
  localparam logic [1:0] REG_BYTE_CNT  = 2'd2;

  typedef struct packed {
    logic [LINE_W-1:0]  scl_line;
    logic [LINE_W-1:0]  sda_line;
    logic [COUNT_W-1:0] byte_count;
  } cfg_t;

  typedef struct packed {
    logic               last_byte;
    logic [COUNT_W-1:0] byte_index;
    logic               nack;
    logic [BYTE_W-1:0]  byte_value;
  } result_t;

endpackage

`default_nettype wire

[design/i2cbd_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cbd_core
  import i2cbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic [SAMPLE_W-1:0] in_word,
  input  wire cfg_t                cfg,
  output logic                     res_valid,
  output result_t                  res
);

  logic                in_transfer, in_transfer_next;
  logic                prev_scl, prev_scl_next;
  logic                prev_sda, prev_sda_next;
  logic [BITPOS_W-1:0] bit_position, bit_position_next;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next;
  logic                ack_pending, ack_pending_next;
  logic [COUNT_W-1:0]  bytes_done, bytes_done_next;

  logic                scl, sda, last, rise_ok;
  logic [COUNT_W:0]    done_plus;

  assign scl       = in_word[cfg.scl_line];
  assign sda       = in_word[cfg.sda_line];
  assign done_plus = {1'b0, bytes_done} + {{COUNT_W{1'b0}}, 1'b1};
  assign last      = done_plus >= {1'b0, cfg.byte_count};

  always_comb begin
    in_transfer_next  = in_transfer;
    bit_position_next = bit_position;
    shift_byte_next   = shift_byte;
    ack_pending_next  = ack_pending;
    bytes_done_next   = bytes_done;
    prev_scl_next     = scl;
    prev_sda_next     = sda;
    rise_ok           = 1'b0;
    res_valid         = 1'b0;
    res.byte_value    = shift_byte;
    res.nack          = sda;
    res.byte_index    = bytes_done;
    res.last_byte     = last;

    if (!in_transfer) begin
      // start condition: sda falls while scl high
      if (prev_sda && !sda && scl) begin
        in_transfer_next  = 1'b1;
        bit_position_next = BITPOS_FIRST;
        shift_byte_next   = '0;
        ack_pending_next  = 1'b0;
        bytes_done_next   = '0;
      end
    end else begin
      rise_ok = 1'b1;
      if (ack_pending) begin
        res_valid        = 1'b1;
        ack_pending_next = 1'b0;
        bytes_done_next  = done_plus[COUNT_W-1:0];
        if (last) begin
          in_transfer_next  = 1'b0;
          bit_position_next = BITPOS_FIRST;
          rise_ok           = 1'b0;
        end
      end
      if (rise_ok && !prev_scl && scl) begin
        if (bit_position[BITPOS_W-1]) begin
          ack_pending_next  = 1'b1;
          bit_position_next = BITPOS_FIRST;
        end else begin
          shift_byte_next[bit_position[2:0]] = sda;
          bit_position_next = bit_position - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_transfer  <= 1'b0;
      prev_scl     <= 1'b1;
      prev_sda     <= 1'b1;
      bit_position <= BITPOS_FIRST;
      shift_byte   <= '0;
      ack_pending  <= 1'b0;
      bytes_done   <= '0;
    end else if (adv) begin
      in_transfer  <= in_transfer_next;
      prev_scl     <= prev_scl_next;
      prev_sda     <= prev_sda_next;
      bit_position <= bit_position_next;
      shift_byte   <= shift_byte_next;
      ack_pending  <= ack_pending_next;
      bytes_done   <= bytes_done_next;
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_ack: assert property (@(posedge clk) disable iff (rst)
    !in_transfer |-> !ack_pending)
    else $error("ack pending outside a transfer");

  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    adv && res_valid && res.last_byte |=> !in_transfer)
    else $error("no re-arm after last byte");

  a_ack_once: assert property (@(posedge clk) disable iff (rst)
    adv && ack_pending |=> !ack_pending)
    else $error("acknowledge captured twice");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    adv && res_valid && !res.last_byte |=>
      bytes_done == $past(bytes_done) + 9'd1)
    else $error("byte counter did not advance");
`endif

endmodule

`default_nettype wire

[design/i2c_sampled_bus_byte_decoder_top.sv]
// channel   | handshake                 | payload
// s (in)    | s_tvalid / s_tready       | s_tdata: sample_word
// m (out)   | m_tvalid / m_tready       | m_tdata: byte_value, nack, byte_index; m_tlast
// apb (cfg) | psel, penable, pwrite     | paddr, pwdata, prdata
//
// one sample a cycle while the output is not held; a decoded byte leaves after its acknowledge sample
// input register, decode logic, then output register; stall only if output is held
// synchronous reset returns to hunting for a start with both lines idle high
// register writes take effect on the next sample decoded
`timescale 1ns / 1ps
`default_nettype none

module i2c_sampled_bus_byte_decoder_top
  import i2cbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] byte_value, [8] nack, [17:9] byte_index
  output logic             m_tlast,   // last_byte
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t                cfg;
  logic                stage_valid;
  logic [SAMPLE_W-1:0] stage_word;
  logic                adv;
  logic                res_valid;
  result_t             res;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scl_line   <= 4'd0;
      cfg.sda_line   <= 4'd1;
      cfg.byte_count <= 9'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_SCL_LINE: cfg.scl_line   <= pwdata[LINE_W-1:0];
        REG_SDA_LINE: cfg.sda_line   <= pwdata[LINE_W-1:0];
        REG_BYTE_CNT: cfg.byte_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCL_LINE: prdata = {{(32-LINE_W){1'b0}}, cfg.scl_line};
      REG_SDA_LINE: prdata = {{(32-LINE_W){1'b0}}, cfg.sda_line};
      REG_BYTE_CNT: prdata = {{(32-COUNT_W){1'b0}}, cfg.byte_count};
      default:      prdata = '0;
    endcase
  end

  assign adv      = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_word <= s_tdata;
    end
  end

  i2cbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_word   (stage_word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      m_tdata <= {6'd0, res.byte_index, res.nack, res.byte_value};
      m_tlast <= res.last_byte;
    end
  end

endmodule

`default_nettype wire

[test/i2cbd_byte_checker.sv]
`timescale 1ns / 1ps

module i2cbd_byte_checker
  import i2cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_word
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [7:0] byte_value, [8] nack, [17:9] byte_index
  input  logic        m_tlast,   // last_byte
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          samples_seen,
  output int          bytes_checked,
  output int          nacks_seen
);

  logic [LINE_W-1:0]   scl_sel;
  logic [LINE_W-1:0]   sda_sel;
  logic [COUNT_W-1:0]  count_cfg;

  logic                busy;
  logic                last_scl;
  logic                last_sda;
  logic                ack_wait;
  logic [BITPOS_W-1:0] bit_pos;
  logic [BYTE_W-1:0]   shreg;
  logic [COUNT_W-1:0]  done_count;

  result_t expected_bytes[$];
  int fails    = 0;
  int nsamples = 0;
  int nbytes   = 0;
  int nnacks   = 0;

  task automatic decode_sample(input logic [SAMPLE_W-1:0] word);
    logic scl;
    logic sda;
    logic closes;
    result_t exp_byte;
    scl = word[scl_sel];
    sda = word[sda_sel];
    closes = 1'b0;
    if (!busy) begin
      // hunting for sda falling while scl is high
      if (last_sda && !sda && scl) begin
        busy = 1'b1;
        bit_pos = BITPOS_FIRST;
        shreg = '0;
        ack_wait = 1'b0;
        done_count = '0;
      end
    end else begin
      if (ack_wait) begin
        closes = ({1'b0, done_count} + 10'd1) >= {1'b0, count_cfg};
        exp_byte.byte_value = shreg;
        exp_byte.nack = sda;
        exp_byte.byte_index = done_count;
        exp_byte.last_byte = closes;
        expected_bytes.insert(expected_bytes.size(), exp_byte);
        ack_wait = 1'b0;
        done_count = done_count + 1'b1;
        if (closes) begin
          busy = 1'b0;
          bit_pos = BITPOS_FIRST;
        end
      end
      if (!closes && !last_scl && scl) begin
        if (bit_pos > BITPOS_FIRST) begin
          ack_wait = 1'b1;
          bit_pos = BITPOS_FIRST;
        end else begin
          shreg[bit_pos[2:0]] = sda;
          bit_pos = bit_pos - 1'b1;
        end
      end
    end
    last_scl = scl;
    last_sda = sda;
  endtask

  task automatic check_byte(input logic [23:0] data, input logic tlast);
    result_t exp_byte;
    if (expected_bytes.size() == 0) begin
      $error("decoded byte 0x%0h index %0d arrived with none expected", data[7:0], data[17:9]);
      fails++;
    end else begin
      exp_byte = expected_bytes.pop_front();
      if (data[7:0] !== exp_byte.byte_value) begin
        $error("byte_value: expected 0x%0h, got 0x%0h", exp_byte.byte_value, data[7:0]);
        fails++;
      end
      if (data[8] !== exp_byte.nack) begin
        $error("nack: expected %0b, got %0b", exp_byte.nack, data[8]);
        fails++;
      end
      if (data[17:9] !== exp_byte.byte_index) begin
        $error("byte_index: expected %0d, got %0d", exp_byte.byte_index, data[17:9]);
        fails++;
      end
      if (tlast !== exp_byte.last_byte) begin
        $error("last_byte: expected %0b, got %0b", exp_byte.last_byte, tlast);
        fails++;
      end
    end
    nbytes++;
    if (data[8] === 1'b1) nnacks++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scl_sel = 4'd0;
      sda_sel = 4'd1;
      count_cfg = 9'd1;
      busy = 1'b0;
      last_scl = 1'b1;
      last_sda = 1'b1;
      ack_wait = 1'b0;
      bit_pos = BITPOS_FIRST;
      shreg = '0;
      done_count = '0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SCL_LINE: scl_sel = pwdata[LINE_W-1:0];
          REG_SDA_LINE: sda_sel = pwdata[LINE_W-1:0];
          REG_BYTE_CNT: count_cfg = pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_byte(m_tdata, m_tlast);
      if (s_tvalid && s_tready) begin
        decode_sample(s_tdata);
        nsamples++;
      end
    end
    mismatches <= fails;
    pending <= expected_bytes.size();
    samples_seen <= nsamples;
    bytes_checked <= nbytes;
    nacks_seen <= nnacks;
  end

endmodule

[test/i2c_sampled_bus_byte_decoder_top_test.sv]
`timescale 1ns / 1ps

module i2c_sampled_bus_byte_decoder_top_test;
  import i2cbd_pkg::*;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = 4'd0;
  logic [31:0] pwdata  = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int samples_seen;
  int bytes_checked;
  int nacks_seen;

  logic [3:0] scl_pos = 4'd0;
  logic [3:0] sda_pos = 4'd1;
  bit hold_levels = 1'b0;
  bit glitches    = 1'b0;
  int send_quiet  = 0;
  int recv_quiet  = 0;
  int samples_sent = 0;
  int transfers_sent = 0;
  int reg_writes = 0;
  int bytes_taken = 0;

  always #4 clk = ~clk;

  i2c_sampled_bus_byte_decoder_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2cbd_byte_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending), .samples_seen(samples_seen),
    .bytes_checked(bytes_checked), .nacks_seen(nacks_seen)
  );

  // mostly short random waits, now and then a run with none
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(10, 60);
      return 0;
    end
    return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [15:0] bus_word(input logic scl, input logic sda);
    logic [15:0] w;
    w = 16'($urandom);
    w[scl_pos] = scl;
    w[sda_pos] = sda;
    return w;
  endfunction

  task automatic send_sample(input logic [15:0] w);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  task automatic drive_bus(input logic scl, input logic sda);
    send_sample(bus_word(scl, sda));
    if (hold_levels && $urandom_range(0, 3) == 0) send_sample(bus_word(scl, sda));
  endtask

  task automatic clock_bit(input logic b);
    drive_bus(1'b0, b);
    drive_bus(1'b1, b);
    // sda moving while scl is high: a start or stop inside the transfer
    if (glitches && $urandom_range(0, 24) == 0) drive_bus(1'b1, !b);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic nack);
    for (int i = 7; i >= 0; i--) clock_bit(value[i]);
    clock_bit(nack);
    drive_bus(1'b0, nack);
  endtask

  task automatic send_transfer(input int nbytes, input bit with_stop);
    drive_bus(1'b1, 1'b1);
    drive_bus(1'b1, 1'b0);
    drive_bus(1'b0, 1'b0);
    for (int k = 0; k < nbytes; k++) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    if (with_stop) begin
      drive_bus(1'b0, 1'b0);
      drive_bus(1'b1, 1'b0);
      drive_bus(1'b1, 1'b1);
    end else begin
      drive_bus(1'b0, 1'b1);
      drive_bus(1'b1, 1'b1);
    end
    transfers_sent++;
  endtask

  task automatic send_broken();
    drive_bus(1'b1, 1'b1);
    drive_bus(1'b1, 1'b0);
    drive_bus(1'b0, 1'b0);
    repeat ($urandom_range(1, 12)) clock_bit(1'($urandom_range(0, 1)));
    drive_bus(1'b0, 1'b0);
    drive_bus(1'b1, 1'b0);
    drive_bus(1'b1, 1'b1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCL_LINE: scl_pos = val[3:0];
      REG_SDA_LINE: sda_pos = val[3:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [3:0] scl_p, input logic [3:0] sda_p, input int count);
    write_reg(REG_SCL_LINE, {28'd0, scl_p});
    write_reg(REG_SDA_LINE, {28'd0, sda_p});
    write_reg(REG_BYTE_CNT, count);
  endtask

  // the decoder may still be busy with a sample that yields nothing
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(input int phase);
    logic [3:0] scl_p;
    logic [3:0] sda_p;
    int count;
    int nb;
    int n_xfer;
    case (phase)
      0: begin scl_p = 4'd15; sda_p = 4'd0; count = 0; end
      1: begin scl_p = 4'd0; sda_p = 4'd15; count = 511; end
      2: begin scl_p = 4'd7; sda_p = 4'd7; count = 3; end
      default: begin
        scl_p = 4'($urandom);
        sda_p = 4'($urandom);
        if (sda_p == scl_p) sda_p = scl_p ^ 4'h1;
        count = $urandom_range(1, 6);
      end
    endcase
    set_config(scl_p, sda_p, count);
    hold_levels = 1'($urandom_range(0, 1));
    glitches = 1'b1;
    if (phase == 2) begin
      n_xfer = 0;
      repeat (40) send_sample(16'($urandom));
    end else begin
      n_xfer = $urandom_range(2, 5);
    end
    repeat (n_xfer) begin
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(3, 20)) send_sample(16'($urandom));
      case ($urandom_range(0, 9))
        0: send_broken();
        1: send_transfer($urandom_range(1, 4), 1'b1);
        default: begin
          nb = (count == 0) ? 1 : count;
          if (nb > 6) nb = $urandom_range(1, 4);
          send_transfer(nb, 1'($urandom_range(0, 1)));
        end
      endcase
    end
    drain();
  endtask

  // receiver side, with two long hold-offs to back the decoder up
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_quiet);
      if (bytes_taken == 30 || bytes_taken == 200) gap = 400;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      bytes_taken++;
    end
  end

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: scl on bit 0, sda on bit 1, one byte per transfer
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFD);
    send_byte(8'hA5, 1'b1);
    drain();

    phase = 0;
    while (samples_sent < 900) begin
      random_phase(phase);
      phase++;
    end

    // back to hunting, then a short run under a byte count of 257
    glitches = 1'b0;
    hold_levels = 1'b0;
    set_config(4'd3, 4'd12, 1);
    send_transfer(1, 1'b1);
    send_transfer(1, 1'b1);
    drain();
    glitches = 1'b1;
    write_reg(REG_BYTE_CNT, 257);
    send_transfer(3, 1'b1);
    drain();

    repeat (10) @(posedge clk);
    $display("run covered %0d samples in %0d transfers, %0d register writes",
             samples_seen, transfers_sent, reg_writes);
    $display("checked %0d decoded bytes, %0d of them not acknowledged",
             bytes_checked, nacks_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
